// ===== rtl/actc_pkg.sv =====
// ----------------------------------------------------------------------------
// actc_pkg
// Shared types, constants and AES / BCD helper functions for the token unit.
// ----------------------------------------------------------------------------
`default_nettype none
package actc_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int N_ROUNDS   = 10;
  localparam int N_CHAIN    = 5;
  localparam int N_DIGITS   = 8;

  localparam logic [2:0] REG_SEED_HI = 3'd0;
  localparam logic [2:0] REG_SEED_LO = 3'd1;
  localparam logic [2:0] REG_SERIAL  = 3'd2;
  localparam logic [2:0] REG_PIN     = 3'd3;
  localparam logic [2:0] REG_PIN_LEN = 3'd4;

  localparam logic [7:0] PAD_TIME = 8'haa;
  localparam logic [7:0] PAD_TAIL = 8'hbb;

  typedef struct packed {
    logic [47:0] tb;
    logic [1:0]  sel;
  } item_t;

  localparam logic [7:0] RCON [10] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 sits in the top bits
  function automatic logic [7:0] byte_of(input logic [127:0] s, input int idx);
    return s[127-8*idx -: 8];
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[c*4+j] = SBOX[byte_of(s, ((c + j) % 4) * 4 + j)];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ x ^ xt(a0 ^ a1);
        t[c*4+1] = a1 ^ x ^ xt(a1 ^ a2);
        t[c*4+2] = a2 ^ x ^ xt(a2 ^ a3);
        t[c*4+3] = a3 ^ x ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ tmp;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // plaintext of chain step k: the first cnt time bytes, 0xaa pad, serial, 0xbb tail
  function automatic logic [127:0] build_pt(input int k, input logic [47:0] tb,
                                            input logic [31:0] serial);
    logic [127:0] p;
    int           cnt;
    cnt = (k == 4) ? 8 : k + 2;
    for (int j = 0; j < 8; j++) begin
      if (j >= cnt)     p[127-8*j -: 8] = PAD_TIME;
      else if (j < 6)   p[127-8*j -: 8] = tb[47-8*j -: 8];
      else              p[127-8*j -: 8] = 8'h00;
    end
    p[63:32] = serial;
    p[31:0]  = {PAD_TAIL, PAD_TAIL, PAD_TAIL, PAD_TAIL};
    return p;
  endfunction

  // value below 100 to two BCD digits
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = {8'd0, v} * 15'd205;
    t = p[14:11];
    u = v - 7'({3'd0, t} * 7'd10);
    return {t, u[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/actc_front.sv =====
// ----------------------------------------------------------------------------
// actc_front
// Accepts time beats and turns them into BCD time bytes plus word select.
// ----------------------------------------------------------------------------
`default_nettype none
module actc_front (
  input  wire logic [13:0]   year,
  input  wire logic [3:0]    month,
  input  wire logic [4:0]    day,
  input  wire logic [4:0]    hour,
  input  wire logic [5:0]    minute,
  output actc_pkg::item_t    item
);
  import actc_pkg::*;

  logic [26:0] yprod;
  logic [7:0]  q100;
  logic [6:0]  yhi;
  logic [13:0] ylo;

  always_comb begin
    yprod = {13'd0, year} * 27'd5243;
    q100  = yprod[26:19];
    yhi   = (q100 >= 8'd100) ? 7'(q100 - 8'd100) : q100[6:0];
    ylo   = year - 14'({6'd0, q100} * 14'd100);
    item.tb  = {bcd2(yhi), bcd2(ylo[6:0]), bcd2({3'd0, month}), bcd2({2'd0, day}),
                bcd2({2'd0, hour}), bcd2({1'b0, minute[5:2], 2'b00})};
    item.sel = minute[1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/actc_fifo.sv =====
// ----------------------------------------------------------------------------
// actc_fifo
// Short queue between the front and the cipher pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module actc_fifo #(
  parameter int DEPTH = actc_pkg::FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  actc_pkg::item_t      push_data,
  output logic                 full,
  input  wire logic            pop,
  output actc_pkg::item_t      pop_data,
  output logic                 not_empty
);
  import actc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (do_pop)  rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/actc_back.sv =====
// ----------------------------------------------------------------------------
// actc_back
// Fifty-stage chained AES pipeline, one round per stage, then eight digit
// stages that pick the word, split it into decimal digits and add the PIN.
// ----------------------------------------------------------------------------
`default_nettype none
module actc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  actc_pkg::item_t      in_item,
  output logic                 in_ready,
  input  wire logic [127:0]    seed,
  input  wire logic [31:0]     serial,
  input  wire logic [31:0]     pin,
  input  wire logic [3:0]      pin_len,
  output logic                 out_valid,
  output logic [31:0]          out_code,
  input  wire logic            out_ready
);
  import actc_pkg::*;

  localparam int NS = N_CHAIN * N_ROUNDS;

  logic         en;
  logic [127:0] st_r  [NS];
  logic [127:0] rk_r  [NS];
  item_t        it_r  [NS];
  logic         vld_r [NS];

  logic [31:0]  dv_r   [N_DIGITS];
  logic [31:0]  dres_r [N_DIGITS];
  logic         dvld_r [N_DIGITS];
  logic [3:0]   plen;

  assign en        = !dvld_r[N_DIGITS-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = dvld_r[N_DIGITS-1];
  assign out_code  = dres_r[N_DIGITS-1];
  assign plen      = (pin_len > 4'd8) ? 4'd8 : pin_len;

  for (genvar n = 0; n < NS; n++) begin : g_rnd
    localparam int K = n / N_ROUNDS;
    localparam int R = n % N_ROUNDS;
    logic [127:0] s_in, k_in, k_nxt, s_nxt;
    item_t        it_in;
    logic         v_in;

    if (n == 0) begin : g_first
      assign it_in = in_item;
      assign v_in  = in_valid;
      assign k_in  = seed;
      assign s_in  = build_pt(K, in_item.tb, serial) ^ seed;
    end else if (R == 0) begin : g_link
      assign it_in = it_r[n-1];
      assign v_in  = vld_r[n-1];
      assign k_in  = st_r[n-1];
      assign s_in  = build_pt(K, it_r[n-1].tb, serial) ^ st_r[n-1];
    end else begin : g_mid
      assign it_in = it_r[n-1];
      assign v_in  = vld_r[n-1];
      assign k_in  = rk_r[n-1];
      assign s_in  = st_r[n-1];
    end

    always_comb begin
      k_nxt = key_next(k_in, RCON[R]);
      s_nxt = aes_round(s_in, R == N_ROUNDS - 1) ^ k_nxt;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[n] <= s_nxt;
        rk_r[n] <= k_nxt;
        it_r[n] <= it_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[n] <= 1'b0;
      end else if (en) begin
        vld_r[n] <= v_in;
      end
    end
  end

  for (genvar d = 0; d < N_DIGITS; d++) begin : g_dig
    logic [31:0] v_in, r_in, q, res_nxt;
    logic [63:0] prod;
    logic [31:0] rem;
    logic [4:0]  sum;
    logic [3:0]  dig;
    logic        vv;

    if (d == 0) begin : g_first
      assign v_in = st_r[NS-1][127 - 32*it_r[NS-1].sel -: 32];
      assign r_in = '0;
      assign vv   = vld_r[NS-1];
    end else begin : g_next
      assign v_in = dv_r[d-1];
      assign r_in = dres_r[d-1];
      assign vv   = dvld_r[d-1];
    end

    always_comb begin
      prod = {32'd0, v_in} * 64'h0000_0000_CCCC_CCCD;
      q    = {3'd0, prod[63:35]};
      rem  = v_in - {q[28:0], 3'b000} - {q[30:0], 1'b0};
      sum  = {1'b0, rem[3:0]};
      if (4'(d) < plen) sum = sum + {1'b0, pin[4*d +: 4]};
      if (sum >= 5'd20)      sum = sum - 5'd20;
      else if (sum >= 5'd10) sum = sum - 5'd10;
      dig = sum[3:0];
      res_nxt = r_in;
      res_nxt[4*d +: 4] = dig;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[d]   <= q;
        dres_r[d] <= res_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[d] <= 1'b0;
      end else if (en) begin
        dvld_r[d] <= vv;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aes_chain_time_token_code_unit.sv =====
// ----------------------------------------------------------------------------
// aes_chain_time_token_code_unit
// Time-based eight-digit token code from five chained AES-128 encryptions.
// ----------------------------------------------------------------------------
// in_*  : one beat per UTC time (year, month, day, hour, minute).
// out_* : one beat per input, token code as eight packed BCD digits.
// cfg_* : register writes (seed high/low, serial, PIN digits, PIN length),
//         always ready; write only while no beat is in flight.
// Throughput: one beat per cycle while out_tready stays high. Each of the 50
// AES rounds has its own pipeline stage with its own key expansion step,
// followed by eight decimal digit stages.
// Path: an accepted beat is written into the input queue, then passes the 50
// round stages and the 8 digit stages before out_tvalid rises.
// Stall: when a result waits with out_tready low the pipeline holds; the
// input queue keeps taking beats until it is full, then in_tready drops.
// Reset: zeroes config registers and valid flags, emptying queue and pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_chain_time_token_code_unit #(
  parameter int FIFO_DEPTH = actc_pkg::FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // year[13:0], month[17:14], day[22:18],
                                       // hour[27:23], minute[33:28]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // token_code[31:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import actc_pkg::*;

  logic [63:0] seed_hi_r, seed_lo_r;
  logic [31:0] serial_r, pin_r;
  logic [3:0]  pin_len_r;

  item_t front_item, q_item;
  logic  q_full, q_ne, back_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_hi_r <= '0;
      seed_lo_r <= '0;
      serial_r  <= '0;
      pin_r     <= '0;
      pin_len_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEED_HI: seed_hi_r <= cfg_data;
        REG_SEED_LO: seed_lo_r <= cfg_data;
        REG_SERIAL:  serial_r  <= cfg_data[31:0];
        REG_PIN:     pin_r     <= cfg_data[31:0];
        REG_PIN_LEN: pin_len_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  actc_front u_front (
    .year   (in_tdata[13:0]),
    .month  (in_tdata[17:14]),
    .day    (in_tdata[22:18]),
    .hour   (in_tdata[27:23]),
    .minute (in_tdata[33:28]),
    .item   (front_item)
  );

  assign in_tready = !q_full;

  actc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (front_item),
    .full      (q_full),
    .pop       (back_ready),
    .pop_data  (q_item),
    .not_empty (q_ne)
  );

  actc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_ne),
    .in_item   (q_item),
    .in_ready  (back_ready),
    .seed      ({seed_hi_r, seed_lo_r}),
    .serial    (serial_r),
    .pin       (pin_r),
    .pin_len   (pin_len_r),
    .out_valid (out_tvalid),
    .out_code  (out_tdata),
    .out_ready (out_tready)
  );

endmodule
`default_nettype wire

// ===== sim/tb_aes_chain_time_token_code_unit.sv =====
// ----------------------------------------------------------------------------
// tb_aes_chain_time_token_code_unit
// Drives UTC times into the token unit and checks each token code against a
// behavioral AES chain computed here. The block is reconfigured several times
// while idle. Random idling on both sides, plus one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_aes_chain_time_token_code_unit;
  import actc_pkg::*;

  localparam int LATENCY   = 59;
  localparam int WDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  aes_chain_time_token_code_unit dut (.*);

  logic [63:0] seed_hi_q, seed_lo_q;
  logic [31:0] serial_q, pin_q;
  logic [3:0]  pin_len_q;

  logic [31:0] token_q [$];
  int          errors;
  int          idle_pct_in, idle_pct_out;
  bit          hold_out;
  int          wdog;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor ---------------------------------------------------------------
  logic [7:0] sb [256];
  logic [7:0] rc [10];
  initial begin
    sb = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
  end

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned v);
    return {4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  // byte arrays, index 0 is the first byte
  function automatic void encrypt128(ref logic [7:0] key [16], input logic [7:0] pt [16]);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tt [16];
    logic [7:0] w4 [4];
    logic [7:0] f, a0, a1, a2, a3, x;
    for (int i = 0; i < 16; i++) rk[i] = key[i];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w4[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        f = w4[0];
        w4[0] = sb[w4[1]] ^ rc[i/16-1];
        w4[1] = sb[w4[2]];
        w4[2] = sb[w4[3]];
        w4[3] = sb[f];
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w4[j];
    end
    for (int i = 0; i < 16; i++) st[i] = pt[i] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++) tt[c*4+j] = sb[st[((c+j)%4)*4+j]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tt[c*4]; a1 = tt[c*4+1]; a2 = tt[c*4+2]; a3 = tt[c*4+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          tt[c*4]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
          tt[c*4+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
          tt[c*4+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
          tt[c*4+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tt[i] ^ rk[r*16+i];
    end
    for (int i = 0; i < 16; i++) key[i] = st[i];
  endfunction

  function automatic logic [31:0] token_of(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy,
                                           logic [4:0] hr, logic [5:0] mi);
    logic [7:0]  tb [8];
    logic [7:0]  key [16];
    logic [7:0]  pt [16];
    int          cnt [5];
    int unsigned code, dig, plen;
    logic [31:0] res;
    int          s;
    cnt = '{2, 3, 4, 5, 8};
    tb[0] = to_bcd(yr / 100);
    tb[1] = to_bcd(yr);
    tb[2] = to_bcd(mo);
    tb[3] = to_bcd(dy);
    tb[4] = to_bcd(hr);
    tb[5] = to_bcd({mi[5:2], 2'b00});
    tb[6] = 8'h00;
    tb[7] = 8'h00;
    for (int i = 0; i < 8; i++) begin
      key[i]   = seed_hi_q[63-8*i -: 8];
      key[8+i] = seed_lo_q[63-8*i -: 8];
    end
    for (int k = 0; k < 5; k++) begin
      for (int i = 0; i < 8; i++) pt[i] = (i < cnt[k]) ? tb[i] : PAD_TIME;
      for (int i = 0; i < 4; i++) pt[8+i] = serial_q[31-8*i -: 8];
      for (int i = 12; i < 16; i++) pt[i] = PAD_TAIL;
      encrypt128(key, pt);
    end
    s = mi[1:0] * 4;
    code = {key[s], key[s+1], key[s+2], key[s+3]};
    plen = (pin_len_q > 8) ? 8 : pin_len_q;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      dig = code % 10;
      code = code / 10;
      if (i < plen) dig += pin_q[4*i +: 4];
      res[4*i +: 4] = 4'(dig % 10);
    end
    return res;
  endfunction

  // driving -----------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SEED_HI: seed_hi_q = val;
      REG_SEED_LO: seed_lo_q = val;
      REG_SERIAL:  serial_q  = val[31:0];
      REG_PIN:     pin_q     = val[31:0];
      REG_PIN_LEN: pin_len_q = val[3:0];
      default: ;
    endcase
  endtask

  task automatic send_time(logic [13:0] yr, logic [3:0] mo, logic [4:0] dy,
                           logic [4:0] hr, logic [5:0] mi);
    while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, mi, hr, dy, mo, yr};
    token_q.push_back(token_of(yr, mo, dy, hr, mi));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    int n;
    stop_sending();
    n = 0;
    while (token_q.size() != 0 && n < 50 * WDOG_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_random_time();
    send_time(14'($urandom_range(9999)), 4'($urandom_range(1, 12)),
              5'($urandom_range(1, 31)), 5'($urandom_range(23)),
              6'($urandom_range(59)));
  endtask

  task automatic send_raw_time();
    send_time(14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom));
  endtask

  // checking ----------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (token_q.size() == 0) begin
        $error("unexpected token_code beat %h", out_tdata);
        errors++;
      end else begin
        if (out_tdata !== token_q[0]) begin
          $error("token_code mismatch: expected %h actual %h", token_q[0], out_tdata);
          errors++;
        end
        void'(token_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_out) out_tready <= 1'b0;
    else out_tready <= !(idle_pct_out > 0 && $urandom_range(99) < idle_pct_out);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("tb_aes_chain_time_token_code_unit failed");
      $finish;
    end
  end

  // tests -------------------------------------------------------------------
  task automatic test_reset_config();
    for (int i = 0; i < 6; i++) send_random_time();
    drain();
  endtask

  task automatic test_field_extremes();
    write_reg(REG_SEED_HI, 64'h0001020304050607);
    write_reg(REG_SEED_LO, 64'h08090a0b0c0d0e0f);
    write_reg(REG_SERIAL, 32'h12345678);
    write_reg(REG_PIN, 32'h00001234);
    write_reg(REG_PIN_LEN, 4'd4);
    send_time(14'd0, 4'd1, 5'd1, 5'd0, 6'd0);
    send_time(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59);
    send_time(14'h3fff, 4'hf, 5'h1f, 5'h1f, 6'h3f);
    send_time(14'd2024, 4'd0, 5'd0, 5'd24, 6'd60);
    send_time(14'd1900, 4'd6, 5'd15, 5'd12, 6'd1);
    send_time(14'd1999, 4'd7, 5'd16, 5'd13, 6'd2);
    send_time(14'd2000, 4'd8, 5'd17, 5'd14, 6'd3);
    send_time(14'd10000, 4'd13, 5'd30, 5'd25, 6'd61);
    for (int m = 4; m < 8; m++) send_time(14'd2038, 4'd1, 5'd19, 5'd3, 6'(m));
    drain();
  endtask

  task automatic test_pin_and_serial_corners();
    write_reg(REG_SEED_HI, 64'hffffffffffffffff);
    write_reg(REG_SEED_LO, 64'hffffffffffffffff);
    write_reg(REG_SERIAL, 32'hffffffff);
    write_reg(REG_PIN, 32'hffffffff);
    write_reg(REG_PIN_LEN, 4'd15);
    send_time(14'd2025, 4'd3, 5'd4, 5'd5, 6'd6);
    send_time(14'd1, 4'd2, 5'd3, 5'd4, 6'd5);
    drain();
    write_reg(REG_PIN, 32'h99999999);
    write_reg(REG_PIN_LEN, 4'd8);
    write_reg(REG_SERIAL, 32'h0);
    send_time(14'd2025, 4'd3, 5'd4, 5'd5, 6'd6);
    send_time(14'd9, 4'd9, 5'd9, 5'd9, 6'd9);
    drain();
    write_reg(REG_PIN_LEN, 4'd0);
    write_reg(3'd7, 64'hdeadbeefdeadbeef);
    write_reg(3'd5, 64'h1);
    send_time(14'd2025, 4'd3, 5'd4, 5'd5, 6'd6);
    drain();
  endtask

  task automatic test_random_configs();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SEED_HI, {$urandom, $urandom});
      write_reg(REG_SEED_LO, {$urandom, $urandom});
      write_reg(REG_SERIAL, (ph % 2) ? 32'($urandom) : 32'h99999999 & $urandom);
      write_reg(REG_PIN, (ph % 3 == 0) ? 32'($urandom) : 32'h99999999 & $urandom);
      write_reg(REG_PIN_LEN, 4'($urandom_range(15)));
      idle_pct_in  = (ph == 2) ? 0 : 18;
      idle_pct_out = (ph == 2) ? 0 : 18;
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(9) == 0) send_raw_time();
        else send_random_time();
      end
      drain();
    end
    idle_pct_in  = 18;
    idle_pct_out = 18;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 100; i++) send_random_time();
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_tready = 1'b0;
    hold_out = 1'b0;
    wdog = 0;
    errors = 0;
    idle_pct_in = 18;
    idle_pct_out = 18;
    seed_hi_q = '0;
    seed_lo_q = '0;
    serial_q = '0;
    pin_q = '0;
    pin_len_q = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_field_extremes();
    test_pin_and_serial_corners();
    test_random_configs();
    test_backpressure();
    if (errors == 0 && token_q.size() == 0) begin
      $display("tb_aes_chain_time_token_code_unit passed");
    end else begin
      $display("tb_aes_chain_time_token_code_unit failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/actc_pkg.sv
rtl/actc_front.sv
rtl/actc_fifo.sv
rtl/actc_back.sv
rtl/aes_chain_time_token_code_unit.sv
sim/tb_aes_chain_time_token_code_unit.sv
